// ===== rtl/lzf_pkg.sv =====
// Shared types and constants for the LZF block decompressor.
`timescale 1ns / 1ps
package lzf_pkg;
    localparam logic [7:0] LIT_LIMIT = 8'h20;
    localparam logic [4:0] OFS_MASK  = 5'h1F;
    localparam logic [2:0] LEN_EXT   = 3'd7;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_OVER     = 3'd2,
        ST_DIST     = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_CTRL  = 3'd1,
        PH_LIT   = 3'd2,
        PH_LENX  = 3'd3,
        PH_OFS   = 3'd4
    } phase_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch a new input byte into the parser
        logic copy_step; // read/write one history byte
        logic flush;     // clear the chunk once the result is taken
        logic clear_acc;
    } lzf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    emit_now;  // parse produced a literal or end-of-block result
        logic    start_copy;
        logic    copy_done; // last copy byte issued
        logic    chunk_full;
    } lzf_stat_t;
endpackage

// ===== rtl/lzf_if.sv =====
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface lzf_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lzf_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module lzf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/lzf_ctrl.sv =====
// Sequencer: input acceptance, copy loop and result hand-off.
`timescale 1ns / 1ps
module lzf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lzf_pkg::lzf_stat_t stat,
    output lzf_pkg::lzf_cmd_t  cmd
);
    import lzf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PARSE = 5'b00010,
        S_READ  = 5'b00100,
        S_COPY  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next; // copy finished or no copy, flush is the final one

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                cmd.clear_acc = 1'b1;
                if (stat.start_copy)
                begin
                    done_next  = 1'b0;
                    state_next = S_READ;
                end
                else if (stat.emit_now)
                begin
                    done_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                // wait for the registered RAM read
                state_next = S_COPY;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_done)
                begin
                    done_next  = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.chunk_full)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.flush = 1'b1;
                    state_next = done_reg ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/lzf_dp.sv =====
// Datapath: LZF parse state, history window and chunk assembly.
`timescale 1ns / 1ps
module lzf_dp #(
    parameter int WINDOW_BYTES = 8192,
    parameter int CHUNK_BYTES  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic [31:0]        out_limit,
    input  lzf_pkg::lzf_cmd_t  cmd,
    output lzf_pkg::lzf_stat_t stat,
    output logic [63:0]        out_data,
    output logic [3:0]         out_count,
    output logic               out_last,
    output logic               block_end,
    output logic [2:0]         status,
    output logic [31:0]        total_bytes
);
    import lzf_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    phase_t      phase_reg, phase_next;
    logic [5:0]  lit_reg, lit_next;
    logic [12:0] dist_reg, dist_next;
    logic [8:0]  len_reg, len_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] prod_reg, prod_next;
    logic        err_reg, err_next;
    status_t     code_reg, code_next;

    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] lim_in_reg;

    logic [8:0]  left_reg, left_next;   // copy bytes remaining
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  fill_reg, fill_next;
    logic        endb_reg, endb_next;
    status_t     st_reg, st_next;
    logic        start_copy, emit_now;

    logic [7:0]    rdata;
    logic [AW-1:0] waddr, raddr;
    logic          we;
    logic [7:0]    wdata;

    assign waddr = prod_reg[AW-1:0];
    assign raddr = prod_reg[AW-1:0] - AW'(dist_reg) - AW'(1);

    lzf_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg   <= in_byte;
            last_reg   <= in_last;
            lim_in_reg <= out_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            lit_reg   <= '0;
            dist_reg  <= '0;
            len_reg   <= '0;
            limit_reg <= '0;
            prod_reg  <= '0;
            err_reg   <= 1'b0;
            code_reg  <= ST_OK;
            left_reg  <= '0;
            acc_reg   <= '0;
            fill_reg  <= '0;
            endb_reg  <= 1'b0;
            st_reg    <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            dist_reg  <= dist_next;
            len_reg   <= len_next;
            limit_reg <= limit_next;
            prod_reg  <= prod_next;
            err_reg   <= err_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            endb_reg  <= endb_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        phase_t      ph;
        logic        err;
        status_t     code;
        logic [31:0] prod;
        logic [32:0] need;
        logic [13:0] d;
        phase_next = phase_reg;
        lit_next   = lit_reg;
        dist_next  = dist_reg;
        len_next   = len_reg;
        limit_next = limit_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;
        code_next  = code_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        endb_next  = endb_reg;
        st_next    = st_reg;
        start_copy = 1'b0;
        emit_now   = 1'b0;
        we         = 1'b0;
        wdata      = byte_reg;
        ph   = phase_reg;
        err  = err_reg;
        code = code_reg;
        prod = prod_reg;
        need = '0;
        d    = '0;

        if (cmd.clear_acc)
        begin
            acc_next  = '0;
            fill_next = '0;
            endb_next = 1'b0;
            st_next   = ST_OK;
            if (ph == PH_START)
            begin
                limit_next = lim_in_reg;
                prod       = '0;
                err        = 1'b0;
                code       = ST_OK;
                dist_next  = '0;
                len_next   = '0;
                ph         = PH_CTRL;
            end
            if (!err)
            begin
                case (ph)
                    PH_CTRL:
                    begin
                        if (byte_reg < LIT_LIMIT)
                        begin
                            need = {1'b0, prod} + 33'(byte_reg) + 33'd1;
                            if (need > {1'b0, limit_next})
                            begin
                                err  = 1'b1;
                                code = ST_OVER;
                            end
                            else
                            begin
                                lit_next = 6'(byte_reg) + 6'd1;
                                ph       = PH_LIT;
                            end
                        end
                        else
                        begin
                            dist_next = {byte_reg[4:0] & OFS_MASK, 8'h00};
                            len_next  = 9'(byte_reg[7:5]);
                            ph = (byte_reg[7:5] == LEN_EXT) ? PH_LENX : PH_OFS;
                        end
                    end
                    PH_LIT:
                    begin
                        we        = 1'b1;
                        emit_now  = 1'b1;
                        prod      = prod + 32'd1;
                        acc_next  = 64'(byte_reg);
                        fill_next = 4'd1;
                        lit_next  = lit_reg - 6'd1;
                        if (lit_reg == 6'd1)
                        begin
                            ph = PH_CTRL;
                        end
                    end
                    PH_LENX:
                    begin
                        len_next = len_reg + 9'(byte_reg);
                        ph       = PH_OFS;
                    end
                    default:
                    begin
                        dist_next = {dist_reg[12:8], byte_reg};
                        d         = 14'(dist_next) + 14'd1;
                        ph        = PH_CTRL;
                        need      = {1'b0, prod} + 33'(len_reg) + 33'd2;
                        if (32'(d) > prod)
                        begin
                            err  = 1'b1;
                            code = ST_DIST;
                        end
                        else if (need > {1'b0, limit_next})
                        begin
                            err  = 1'b1;
                            code = ST_OVER;
                        end
                        else
                        begin
                            start_copy = 1'b1;
                            left_next  = len_reg + 9'd2;
                        end
                    end
                endcase
            end
            if (last_reg)
            begin
                emit_now  = 1'b1;
                endb_next = 1'b1;
                if (err)
                begin
                    st_next = code;
                end
                else if (ph != PH_CTRL)
                begin
                    st_next = ST_TRUNC;
                end
                else if (prod + 32'(start_copy ? left_next : 9'd0) != limit_next)
                begin
                    st_next = ST_MISMATCH;
                end
                ph       = PH_START;
                lit_next = '0;
            end
            phase_next = ph;
            err_next   = err;
            code_next  = code;
            prod_next  = prod;
        end

        if (cmd.copy_step)
        begin
            we        = 1'b1;
            wdata     = rdata;
            prod_next = prod_reg + 32'd1;
            acc_next  = acc_reg | (64'(rdata) << {fill_reg[2:0], 3'b000});
            fill_next = fill_reg + 4'd1;
            left_next = left_reg - 9'd1;
        end

        if (cmd.flush)
        begin
            acc_next  = '0;
            fill_next = '0;
        end
    end

    assign stat.emit_now   = emit_now;
    assign stat.start_copy = start_copy;
    assign stat.copy_done  = (left_reg == 9'd1);
    assign stat.chunk_full = (fill_reg == 4'(CHUNK_BYTES - 1));

    assign out_data    = acc_reg;
    assign out_count   = fill_reg;
    assign out_last    = (left_reg == 9'd0);
    assign block_end   = endb_reg && (left_reg == 9'd0);
    assign status      = (left_reg == 9'd0) ? st_reg : ST_OK;
    assign total_bytes = prod_reg;
endmodule

// ===== rtl/lzf_block_decompressor.sv =====
// Top level of the LZF block decompressor.
// channel | dir | payload
// in_ch   | in  | in_byte[7:0], in_last, out_limit[31:0]
// out_ch  | out | out_data[63:0], out_count[3:0], out_last, block_end,
//         |     | status[2:0], total_bytes[31:0]
// A byte is latched in S_IDLE and parsed in S_PARSE; a literal adds a result hand-off.
// A back-reference copies each byte by a registered history read in S_READ
// then a write in S_COPY, plus an output hand-off per chunk of up to CHUNK_BYTES.
// Reset clears parse state; history is uninitialized and needs no clearing.
// A stalled output holds the sequencer; no new byte is taken until done.
`timescale 1ns / 1ps
module lzf_block_decompressor #(
    parameter int WINDOW_BYTES = 8192,
    parameter int CHUNK_BYTES  = 8
) (
    input logic clk,
    input logic rst_n,
    lzf_if.sink   in_ch,
    lzf_if.source out_ch
);
    import lzf_pkg::*;

    lzf_cmd_t  cmd;
    lzf_stat_t stat;

    lzf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lzf_dp #(.WINDOW_BYTES(WINDOW_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_ch.payload[7:0]),
        .in_last     (in_ch.payload[8]),
        .out_limit   (in_ch.payload[40:9]),
        .cmd         (cmd),
        .stat        (stat),
        .out_data    (out_ch.payload[63:0]),
        .out_count   (out_ch.payload[67:64]),
        .out_last    (out_ch.payload[68]),
        .block_end   (out_ch.payload[69]),
        .status      (out_ch.payload[72:70]),
        .total_bytes (out_ch.payload[104:73])
    );
endmodule
